// ===== hw/rtl/gcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants, lane types and the arctangent table for the
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // iteration counts
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;

  // pipeline depth: input scaling (3), rotation cells, cosine/product
  // stages (5), root cells, vectoring cells, distance scaling (3)
  localparam int LATENCY = 3 + CORDIC_STEPS + 5 + SQRT_STEPS + CORDIC_STEPS + 3;

  // datapath width inside the cordic cells
  localparam int CW = 34;

  localparam logic [30:0] DEG_TO_BAM_MUL = 31'd1281023894;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [31:0] CIRC_CM = 32'd4003017359;
  localparam logic [30:0] HALF_CIRC_CM = 31'd2001508680;

  // arctangent of 2^-i in binary angle units (full turn is 2^32)
  localparam logic [29:0] ATAN_BAM [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } rot_lane_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_lane_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sqrt_lane_t;

endpackage

// ===== hw/rtl/gcd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd channel interfaces
// Valid/ready channels for position pairs and for distances.
// ----------------------------------------------------------------------------
interface gcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] from_lat;
  logic signed [31:0] from_lon;
  logic signed [30:0] to_lat;
  logic signed [31:0] to_lon;

  modport source  (output valid, from_lat, from_lon, to_lat, to_lon, input ready);
  modport sink    (input valid, from_lat, from_lon, to_lat, to_lon, output ready);
  // passive view for observers that only watch transfers
  modport monitor (input valid, ready, from_lat, from_lon, to_lat, to_lon);
endinterface

interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] distance_cm;

  modport source  (output valid, distance_cm, input ready);
  modport sink    (input valid, distance_cm, output ready);
  // passive view for observers that only watch transfers
  modport monitor (input valid, ready, distance_cm);
endinterface

// ===== hw/rtl/gcd_rot_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One rotation-mode cordic iteration on four independent angle lanes.
// ----------------------------------------------------------------------------
module gcd_rot_cell (
  input  logic                clk,
  input  logic                en,
  input  logic [4:0]          step,
  input  gcd_pkg::rot_lane_t  lane_i [4],
  output gcd_pkg::rot_lane_t  lane_r [4]
);

  gcd_pkg::rot_lane_t         lane_nxt [4];
  logic signed [gcd_pkg::CW-1:0] at;
  logic signed [gcd_pkg::CW-1:0] dx [4];
  logic signed [gcd_pkg::CW-1:0] dy [4];

  // micro-rotation towards zero residual angle
  always_comb begin
    at = $signed({4'b0, gcd_pkg::ATAN_BAM[step]});
    for (int k = 0; k < 4; k++) begin
      dx[k] = lane_i[k].y >>> step;
      dy[k] = lane_i[k].x >>> step;
      lane_nxt[k].flip = lane_i[k].flip;
      if (lane_i[k].z >= 0) begin
        lane_nxt[k].x = lane_i[k].x - dx[k];
        lane_nxt[k].y = lane_i[k].y + dy[k];
        lane_nxt[k].z = lane_i[k].z - at;
      end else begin
        lane_nxt[k].x = lane_i[k].x + dx[k];
        lane_nxt[k].y = lane_i[k].y - dy[k];
        lane_nxt[k].z = lane_i[k].z + at;
      end
    end
  end

  // hand on to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

// ===== hw/rtl/gcd_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One restoring square-root step on two lanes, settling one result bit.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic [4:0]           step,
  input  gcd_pkg::sqrt_lane_t  lane_i [2],
  output gcd_pkg::sqrt_lane_t  lane_r [2]
);

  gcd_pkg::sqrt_lane_t lane_nxt [2];
  logic [5:0]          sh;
  logic [63:0]         bitv;
  logic [63:0]         trial [2];

  // trial subtract of the current bit pair
  always_comb begin
    sh   = 6'd62 - {step, 1'b0};
    bitv = 64'd1 << sh;
    for (int k = 0; k < 2; k++) begin
      trial[k] = lane_i[k].res + bitv;
      if (lane_i[k].v >= trial[k]) begin
        lane_nxt[k].v   = lane_i[k].v - trial[k];
        lane_nxt[k].res = (lane_i[k].res >> 1) + bitv;
      end else begin
        lane_nxt[k].v   = lane_i[k].v;
        lane_nxt[k].res = lane_i[k].res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

// ===== hw/rtl/gcd_vec_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One vectoring-mode cordic iteration, driving y towards zero.
// ----------------------------------------------------------------------------
module gcd_vec_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [4:0]         step,
  input  gcd_pkg::vec_lane_t lane_i,
  output gcd_pkg::vec_lane_t lane_r
);

  gcd_pkg::vec_lane_t            lane_nxt;
  logic signed [gcd_pkg::CW-1:0] at;
  logic signed [gcd_pkg::CW-1:0] dx;
  logic signed [gcd_pkg::CW-1:0] dy;

  // micro-rotation accumulating the angle
  always_comb begin
    at = $signed({4'b0, gcd_pkg::ATAN_BAM[step]});
    dx = lane_i.y >>> step;
    dy = lane_i.x >>> step;
    if (lane_i.y >= 0) begin
      lane_nxt.x = lane_i.x + dx;
      lane_nxt.y = lane_i.y - dy;
      lane_nxt.z = lane_i.z + at;
    end else begin
      lane_nxt.x = lane_i.x - dx;
      lane_nxt.y = lane_i.y + dy;
      lane_nxt.z = lane_i.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

// ===== hw/rtl/great_circle_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Haversine distance between two positions, as a chain of cordic and
// square-root cells.
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries a position pair (latitudes and longitudes in 1e-7 degree);
//   out_ch carries the distance in centimetres, saturated at the half
//   circumference. Both are valid/ready channels; a transfer happens when
//   valid and ready are high at a rising edge.
//   Throughput is one pair per cycle unless the output is held. A pair
//   passes input scaling, 24 rotation cells, cosine/product stages, 32 root
//   cells, 24 vectoring cells and distance scaling on its way to out_ch.
//   The whole chain advances together: when a result waits in the output
//   register and the receiver holds ready low, the chain freezes and
//   in_ch.ready drops in the same cycle; it rises again once the result
//   is taken. Results leave in order of arrival.
//   Reset clears all valid flags; there is no other state and no set-up.
// ----------------------------------------------------------------------------
module great_circle_distance_top (
  input  logic            clk,
  input  logic            rst_n,
  gcd_in_if.sink          in_ch,
  gcd_out_if.source       out_ch
);

  localparam int NS = gcd_pkg::CORDIC_STEPS;
  localparam int NQ = gcd_pkg::SQRT_STEPS;
  localparam int LT = gcd_pkg::LATENCY;

  logic          en;
  logic [LT-1:0] vld_r;

  // chain enable: move unless the output is held
  assign en           = !vld_r[LT-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[LT-1];

  // valid flags travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LT-2:0], in_ch.valid};
    end
  end

  // degree to binary angle: magnitude times scale
  logic signed [32:0] ext_c [4];
  logic [31:0]        mag_c [4];
  logic [62:0]        prod_r [4];
  logic               neg_r [4];

  always_comb begin
    ext_c[0] = {{2{in_ch.from_lat[30]}}, in_ch.from_lat};
    ext_c[1] = {in_ch.from_lon[31], in_ch.from_lon};
    ext_c[2] = {{2{in_ch.to_lat[30]}}, in_ch.to_lat};
    ext_c[3] = {in_ch.to_lon[31], in_ch.to_lon};
    for (int k = 0; k < 4; k++) begin
      mag_c[k] = ext_c[k][32] ? 32'(-ext_c[k]) : 32'(ext_c[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= 63'(mag_c[k]) * 63'(gcd_pkg::DEG_TO_BAM_MUL);
        neg_r[k]  <= ext_c[k][32];
      end
    end
  end

  // round and restore sign
  logic [31:0] bam_c [4];
  logic [31:0] bam_r [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bam_c[k] = 32'((prod_r[k] + 63'd536870912) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        bam_r[k] <= neg_r[k] ? -bam_c[k] : bam_c[k];
      end
    end
  end

  // latitudes and angle differences, quadrant-folded into the rotation lanes
  logic [31:0]        ang_c [4];
  logic [31:0]        fold_c [4];
  gcd_pkg::rot_lane_t rot_in_r [4];
  gcd_pkg::rot_lane_t rot_c [NS][4];

  always_comb begin
    ang_c[0] = bam_r[0];
    ang_c[1] = bam_r[2];
    ang_c[2] = bam_r[2] - bam_r[0];
    ang_c[3] = bam_r[3] - bam_r[1];
    for (int k = 0; k < 4; k++) begin
      fold_c[k] = (ang_c[k][31] ^ ang_c[k][30]) ? (ang_c[k] ^ 32'h8000_0000)
                                                : ang_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rot_in_r[k].x    <= gcd_pkg::CORDIC_X0;
        rot_in_r[k].y    <= '0;
        rot_in_r[k].z    <= {{2{fold_c[k][31]}}, fold_c[k]};
        rot_in_r[k].flip <= ang_c[k][31] ^ ang_c[k][30];
      end
    end
  end

  // rotation cells
  for (genvar g = 0; g < NS; g++) begin : g_rot
    if (g == 0) begin : g_first
      gcd_rot_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (5'(g)),
        .lane_i (rot_in_r),
        .lane_r (rot_c[g])
      );
    end else begin : g_next
      gcd_rot_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (5'(g)),
        .lane_i (rot_c[g-1]),
        .lane_r (rot_c[g])
      );
    end
  end

  // clamp cosines, form haversines
  logic signed [33:0] xc_c [4];
  logic signed [33:0] cos_c [4];
  logic signed [33:0] hd_c [2];
  logic signed [31:0] cos1_r, cos2_r, hlat0_r, hlon0_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (rot_c[NS-1][k].x > 34'sd1073741824) begin
        xc_c[k] = 34'sd1073741824;
      end else if (rot_c[NS-1][k].x < -34'sd1073741824) begin
        xc_c[k] = -34'sd1073741824;
      end else begin
        xc_c[k] = rot_c[NS-1][k].x;
      end
      cos_c[k] = rot_c[NS-1][k].flip ? -xc_c[k] : xc_c[k];
    end
    hd_c[0] = 34'sd1073741824 - cos_c[2];
    hd_c[1] = 34'sd1073741824 - cos_c[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos1_r  <= 32'(cos_c[0]);
      cos2_r  <= 32'(cos_c[1]);
      hlat0_r <= 32'(hd_c[0] >>> 1);
      hlon0_r <= 32'(hd_c[1] >>> 1);
    end
  end

  // cos(lat1) * cos(lat2)
  logic signed [63:0] prod1_r;
  logic signed [31:0] hlat1_r, hlon1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= 64'(cos1_r) * 64'(cos2_r);
      hlat1_r <= hlat0_r;
      hlon1_r <= hlon0_r;
    end
  end

  // round product to q30
  logic signed [31:0] cc_r, hlat2_r, hlon2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r    <= 32'((prod1_r + 64'sd536870912) >>> 30);
      hlat2_r <= hlat1_r;
      hlon2_r <= hlon1_r;
    end
  end

  // times hav(dlon)
  logic signed [63:0] prod2_r;
  logic signed [31:0] hlat3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r <= 64'(cc_r) * 64'(hlon2_r);
      hlat3_r <= hlat2_r;
    end
  end

  // a = hav(dlat) + product, clamped to [0, 1]
  logic signed [33:0] asum_c;
  logic [30:0]        a_r;

  always_comb begin
    asum_c = 34'(hlat3_r) + 34'((prod2_r + 64'sd536870912) >>> 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (asum_c < 0) begin
        a_r <= '0;
      end else if (asum_c > 34'sd1073741824) begin
        a_r <= gcd_pkg::ONE_Q30;
      end else begin
        a_r <= 31'(asum_c);
      end
    end
  end

  // root cells for sqrt(a) and sqrt(1 - a)
  gcd_pkg::sqrt_lane_t sq_in_c [2];
  gcd_pkg::sqrt_lane_t sq_c [NQ][2];

  always_comb begin
    sq_in_c[0].v   = {3'b0, a_r, 30'b0};
    sq_in_c[0].res = '0;
    sq_in_c[1].v   = {3'b0, gcd_pkg::ONE_Q30 - a_r, 30'b0};
    sq_in_c[1].res = '0;
  end

  for (genvar g = 0; g < NQ; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      gcd_sqrt_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (5'(g)),
        .lane_i (sq_in_c),
        .lane_r (sq_c[g])
      );
    end else begin : g_next
      gcd_sqrt_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (5'(g)),
        .lane_i (sq_c[g-1]),
        .lane_r (sq_c[g])
      );
    end
  end

  // vectoring cells for atan2(sqrt(a), sqrt(1 - a))
  gcd_pkg::vec_lane_t vec_in_c;
  gcd_pkg::vec_lane_t vec_c [NS];

  always_comb begin
    vec_in_c.x = {3'b0, sq_c[NQ-1][1].res[30:0]};
    vec_in_c.y = {3'b0, sq_c[NQ-1][0].res[30:0]};
    vec_in_c.z = '0;
  end

  for (genvar g = 0; g < NS; g++) begin : g_vec
    if (g == 0) begin : g_first
      gcd_vec_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (5'(g)),
        .lane_i (vec_in_c),
        .lane_r (vec_c[g])
      );
    end else begin : g_next
      gcd_vec_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (5'(g)),
        .lane_i (vec_c[g-1]),
        .lane_r (vec_c[g])
      );
    end
  end

  // central angle, clamped and doubled
  logic signed [gcd_pkg::CW-1:0] zf_c;
  logic [31:0]                   c_r;

  assign zf_c = vec_c[NS-1].z;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf_c < 0) begin
        c_r <= '0;
      end else if (zf_c > 34'sd1073741824) begin
        c_r <= {gcd_pkg::ONE_Q30, 1'b0};
      end else begin
        c_r <= {zf_c[30:0], 1'b0};
      end
    end
  end

  // scale by circumference
  logic [63:0] dprod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dprod_r <= 64'(c_r) * 64'(gcd_pkg::CIRC_CM);
    end
  end

  // round, saturate, output register
  logic [64:0] dsum_c;
  logic [32:0] d_c;
  logic [30:0] dist_r;

  always_comb begin
    dsum_c = 65'(dprod_r) + 65'd2147483648;
    d_c    = dsum_c[64:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (d_c > 33'(gcd_pkg::HALF_CIRC_CM)) ? gcd_pkg::HALF_CIRC_CM : d_c[30:0];
    end
  end

  assign out_ch.distance_cm = dist_r;

endmodule

// ===== hw/rtl/gcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks on the distance block, attached by bind.
// ----------------------------------------------------------------------------
module gcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] distance_cm
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(distance_cm))
    else $error("result changed while stalled");

  // distance never exceeds half the circumference
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> distance_cm <= gcd_pkg::HALF_CIRC_CM)
    else $error("distance beyond saturation value");

  // a ready receiver never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled with free output");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .distance_cm (out_ch.distance_cm)
);
